@@ design/kll_pkg.sv @@
// Shared types, constants and helper functions for the keyword and literal lexer.
package kll_pkg;

	// Default token length limit; a token this long or longer classifies as broken
	localparam int unsigned MAX_TOKEN_LEN_DEF = 256;

	// Result queue sizing
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Scanner modes
	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'b001,
		MODE_COMMENT = 3'b010,
		MODE_TOKEN   = 3'b100
	} mode_t;

	// Token kinds
	localparam logic [4:0] KIND_LITERAL = 5'd0;
	localparam logic [4:0] KIND_IDENT   = 5'd1;
	localparam logic [4:0] KIND_ARG     = 5'd2;
	localparam logic [4:0] KIND_KW0     = 5'd3;
	localparam logic [4:0] KIND_BROKEN  = 5'd25;
	localparam logic [4:0] KIND_END     = 5'd26;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_X     = 8'h78;

	// Keyword table: text right-justified, zero padded on the left
	localparam int unsigned NUM_KW = 22;
	localparam logic [47:0] KW_STR [NUM_KW] = '{
		"defun", "return", "+", "-", "*", "/", "%", "and", "or", "not",
		"lt", "le", "eq", "ge", "gt", "if", "else", "endif", "drop", "dup",
		"swap", "rot"
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd5, 3'd6, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd2, 3'd3,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd5, 3'd4, 3'd3,
		3'd4, 3'd3
	};

	// One entry of the result queue
	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] value;
		logic        last;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	// {valid, nibble} for a hex digit of either case
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (is_digit(c)) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Keyword kind for a short token, KIND_BROKEN when nothing matches
	function automatic logic [4:0] kw_kind(input logic [47:0] word, input logic [2:0] len);
		logic [4:0] k;
		k = KIND_BROKEN;
		for (int i = NUM_KW - 1; i >= 0; i--) begin
			if (len == KW_LEN[i] && word == KW_STR[i]) begin
				k = KIND_KW0 + 5'(i);
			end
		end
		return k;
	endfunction

endpackage

@@ design/keyword_literal_lexer.sv @@
// Keyword and literal lexer: one byte per beat in, one token result per beat out.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------
//  input   | in_valid/in_ready  | character[7:0], end_of_input
//  output  | out_valid/out_ready| token_kind[4:0], token_value[31:0], last_result
//
// A byte is accepted whenever in_ready is high; it is registered, classified against
// the token state in the next cycle and its results (none, one or two) are written
// into an eight-entry result queue. in_ready holds back only when the queue cannot
// take two more results behind the byte already in flight. After reset the lexer is
// between tokens with an empty queue. A stalled output side fills the queue and then
// stops the input.
module keyword_literal_lexer #(
	parameter int unsigned MAX_TOKEN_LEN = kll_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         character,
	input  logic               end_of_input,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         token_kind,
	output logic signed [31:0] token_value,
	output logic               last_result
);
	import kll_pkg::*;

	localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

	// Input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	// Token state
	mode_t            mode_q;
	logic [LEN_W-1:0] len_q;
	logic [47:0]      kw_word_q;
	logic [7:0]       head0_q, head1_q, head2_q;
	logic [31:0]      hex_q, dec_q, arg_q;
	logic             hex_ok_q, dec_ok_q, idt_ok_q, arg_neg_q, arg_stop_q;

	// Result queue
	result_t          fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	// Byte decode
	logic       c_sp, c_dg, c_al;
	logic [4:0] c_hex;
	logic       do_start, do_add;

	// State after the token start clear
	logic [LEN_W-1:0] b_len;
	logic [47:0]      b_word;
	logic [7:0]       b_h0, b_h1, b_h2;
	logic [31:0]      b_hex, b_dec, b_arg;
	logic             b_hexok, b_decok, b_idtok, b_neg, b_stop;

	// State after the byte is added
	logic [LEN_W-1:0] a_len;
	logic [47:0]      a_word;
	logic [7:0]       a_h0, a_h1, a_h2;
	logic [31:0]      a_hex, a_dec, a_arg;
	logic             a_hexok, a_decok, a_idtok, a_neg, a_stop;

	// Finished token
	logic [4:0]  f_kind;
	logic [31:0] f_value;
	logic [4:0]  f_kw;

	mode_t       mode_d;
	result_t     push_a, push_b;
	logic [1:0]  push_n;
	logic        pop;
	logic [CNT_W:0] room_need;

	assign c_sp     = is_space(char_s1);
	assign c_dg     = is_digit(char_s1);
	assign c_al     = is_alpha(char_s1);
	assign c_hex    = hex_val(char_s1);
	assign do_start = (mode_q == MODE_BETWEEN) && !c_sp && (char_s1 != CH_SEMI);
	assign do_add   = do_start || ((mode_q == MODE_TOKEN) && !c_sp);

	// Token start clears the accumulated state
	always_comb begin
		if (do_start) begin
			b_len   = '0;
			b_word  = '0;
			b_h0    = '0;
			b_h1    = '0;
			b_h2    = '0;
			b_hex   = '0;
			b_dec   = '0;
			b_arg   = '0;
			b_hexok = 1'b1;
			b_decok = 1'b1;
			b_idtok = 1'b1;
			b_neg   = 1'b0;
			b_stop  = 1'b0;
		end else begin
			b_len   = len_q;
			b_word  = kw_word_q;
			b_h0    = head0_q;
			b_h1    = head1_q;
			b_h2    = head2_q;
			b_hex   = hex_q;
			b_dec   = dec_q;
			b_arg   = arg_q;
			b_hexok = hex_ok_q;
			b_decok = dec_ok_q;
			b_idtok = idt_ok_q;
			b_neg   = arg_neg_q;
			b_stop  = arg_stop_q;
		end
	end

	// Add one byte to the token: incremental classification
	always_comb begin
		a_len   = (b_len < LEN_MAX) ? b_len + LEN_W'(1) : b_len;
		a_word  = (b_len < LEN_W'(6)) ? {b_word[39:0], char_s1} : b_word;
		a_h0    = (b_len == LEN_W'(0)) ? char_s1 : b_h0;
		a_h1    = (b_len == LEN_W'(1)) ? char_s1 : b_h1;
		a_h2    = (b_len == LEN_W'(2)) ? char_s1 : b_h2;
		a_hex   = b_hex;
		a_dec   = b_dec;
		a_arg   = b_arg;
		a_hexok = b_hexok;
		a_decok = b_decok;
		a_idtok = b_idtok;
		a_neg   = b_neg;
		a_stop  = b_stop;
		// hex digits after the 0x prefix
		if (b_len >= LEN_W'(2)) begin
			if (!c_hex[4]) begin
				a_hexok = 1'b0;
			end else begin
				a_hex = {b_hex[27:0], c_hex[3:0]};
			end
		end
		// decimal digits
		if (c_dg) begin
			a_dec = (b_dec << 3) + (b_dec << 1) + {28'd0, char_s1[3:0]};
		end else if (b_len >= LEN_W'(1)) begin
			a_decok = 1'b0;
		end
		// identifier body
		if (b_len >= LEN_W'(1) && !c_al && !c_dg && char_s1 != CH_US) begin
			a_idtok = 1'b0;
		end
		// argN number: optional sign, then leading digits
		if (b_len >= LEN_W'(3) && !b_stop) begin
			if (b_len == LEN_W'(3) && (char_s1 == CH_PLUS || char_s1 == CH_MINUS)) begin
				if (char_s1 == CH_MINUS) begin
					a_neg = 1'b1;
				end
			end else if (c_dg) begin
				a_arg = (b_arg << 3) + (b_arg << 1) + {28'd0, char_s1[3:0]};
			end else begin
				a_stop = 1'b1;
			end
		end
	end

	// Classify the finished token
	assign f_kw = kw_kind(kw_word_q, len_q[2:0]);

	always_comb begin
		f_value = '0;
		priority if (len_q >= LEN_MAX) begin
			f_kind = KIND_BROKEN;
		end else if (head0_q == CH_ZERO && head1_q == CH_X) begin
			f_kind  = hex_ok_q ? KIND_LITERAL : KIND_BROKEN;
			f_value = hex_ok_q ? hex_q : '0;
		end else if ((head0_q == CH_MINUS && is_digit(head1_q)) || is_digit(head0_q)) begin
			f_kind = dec_ok_q ? KIND_LITERAL : KIND_BROKEN;
			if (dec_ok_q) begin
				f_value = (head0_q == CH_MINUS) ? (32'd0 - dec_q) : dec_q;
			end
		end else if (len_q <= LEN_W'(6) && f_kw != KIND_BROKEN) begin
			f_kind = f_kw;
		end else if (len_q >= LEN_W'(3) && head0_q == CH_A && head1_q == CH_R
				&& head2_q == CH_G) begin
			f_kind  = KIND_ARG;
			f_value = arg_neg_q ? (32'd0 - arg_q) : arg_q;
		end else begin
			f_kind = (is_alpha(head0_q) && idt_ok_q) ? KIND_IDENT : KIND_BROKEN;
		end
	end

	// Next mode for an ordinary byte
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_COMMENT: begin
				if (char_s1 == CH_NL) mode_d = MODE_BETWEEN;
			end
			MODE_TOKEN: begin
				if (c_sp) mode_d = MODE_BETWEEN;
			end
			MODE_BETWEEN: begin
				if (char_s1 == CH_SEMI) mode_d = MODE_COMMENT;
				else if (do_start) mode_d = MODE_TOKEN;
			end
			default: mode_d = MODE_BETWEEN;
		endcase
	end

	// Results of the byte in the input stage
	always_comb begin
		push_a = '{kind: f_kind, value: f_value, last: 1'b1};
		push_b = '{kind: KIND_END, value: 32'd0, last: 1'b1};
		push_n = 2'd0;
		if (valid_s1) begin
			if (eoi_s1) begin
				if (mode_q == MODE_TOKEN) begin
					push_a.last = 1'b0;
					push_n      = 2'd2;
				end else begin
					push_a = push_b;
					push_n = 2'd1;
				end
			end else if (mode_q == MODE_TOKEN && c_sp) begin
				push_n = 2'd1;
			end
		end
	end

	// Handshakes
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign room_need = {1'b0, cnt_q} + (valid_s1 ? (CNT_W+1)'(2) : (CNT_W+1)'(0));
	assign in_ready  = (room_need <= (CNT_W+1)'(FIFO_DEPTH - 2));

	assign token_kind  = fifo_q[rd_q].kind;
	assign token_value = fifo_q[rd_q].value;
	assign last_result = fifo_q[rd_q].last;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= character;
			eoi_s1  <= end_of_input;
		end
	end

	// Token state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_BETWEEN;
			len_q      <= '0;
			kw_word_q  <= '0;
			head0_q    <= '0;
			head1_q    <= '0;
			head2_q    <= '0;
			hex_q      <= '0;
			dec_q      <= '0;
			arg_q      <= '0;
			hex_ok_q   <= 1'b1;
			dec_ok_q   <= 1'b1;
			idt_ok_q   <= 1'b1;
			arg_neg_q  <= 1'b0;
			arg_stop_q <= 1'b0;
		end else if (valid_s1) begin
			if (eoi_s1) begin
				mode_q <= MODE_BETWEEN;
			end else begin
				mode_q <= mode_d;
				if (do_add) begin
					len_q      <= a_len;
					kw_word_q  <= a_word;
					head0_q    <= a_h0;
					head1_q    <= a_h1;
					head2_q    <= a_h2;
					hex_q      <= a_hex;
					dec_q      <= a_dec;
					arg_q      <= a_arg;
					hex_ok_q   <= a_hexok;
					dec_ok_q   <= a_decok;
					idt_ok_q   <= a_idtok;
					arg_neg_q  <= a_neg;
					arg_stop_q <= a_stop;
				end
			end
		end
	end

	// Result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push_n);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_q + PTR_W'(1)] <= push_b;
		end
	end

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, cnt_q} + (CNT_W+1)'(2) <= (CNT_W+1)'(FIFO_DEPTH)))
		else $error("byte in flight without room for its results");

	a_eoi_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && eoi_s1) |=> (mode_q == MODE_BETWEEN))
		else $error("end of input did not return to between tokens");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("token length beyond limit");

	a_comment_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !eoi_s1 && mode_q == MODE_COMMENT) |-> (push_n == 2'd0))
		else $error("result produced inside a comment");

endmodule

@@ dv/keyword_literal_lexer_checker.sv @@
// Scoreboard for the keyword and literal lexer: predicts token results per beat and compares.
module keyword_literal_lexer_checker #(
	parameter int unsigned MAX_LEN = kll_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         character,
	input  logic               end_of_input,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [4:0]         token_kind,
	input  logic signed [31:0] token_value,
	input  logic               last_result,
	output int unsigned        pending_count,
	output int unsigned        mismatch_count,
	output int unsigned        results_checked,
	output logic [26:0]        kinds_seen
);
	import kll_pkg::*;

	typedef enum logic [1:0] {
		SCAN_GAP,
		SCAN_REMARK,
		SCAN_WORD
	} scan_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] value;
		logic        last;
	} token_result_t;

	// Lexer state as the predictor sees it
	scan_t       scan;
	logic [7:0]  head [6];
	int unsigned word_len;
	logic [31:0] hex_sum;
	logic [31:0] dec_sum;
	logic [31:0] arg_sum;
	logic        hex_ok;
	logic        dec_ok;
	logic        name_ok;
	logic        arg_minus;
	logic        arg_done;

	token_result_t expected_tokens [$];

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// Keyword spellings in kind order, starting at KIND_KW0
	function automatic string keyword_spelling(input int idx);
		case (idx)
			0: return "defun";
			1: return "return";
			2: return "+";
			3: return "-";
			4: return "*";
			5: return "/";
			6: return "%";
			7: return "and";
			8: return "or";
			9: return "not";
			10: return "lt";
			11: return "le";
			12: return "eq";
			13: return "ge";
			14: return "gt";
			15: return "if";
			16: return "else";
			17: return "endif";
			18: return "drop";
			19: return "dup";
			20: return "swap";
			default: return "rot";
		endcase
	endfunction

	task automatic open_word();
		foreach (head[i]) head[i] = 8'd0;
		word_len  = 0;
		hex_sum   = 32'd0;
		dec_sum   = 32'd0;
		arg_sum   = 32'd0;
		hex_ok    = 1'b1;
		dec_ok    = 1'b1;
		name_ok   = 1'b1;
		arg_minus = 1'b0;
		arg_done  = 1'b0;
	endtask

	// Fold one byte into every candidate classification at once
	task automatic absorb_byte(input logic [7:0] c);
		int unsigned at;
		logic        nib_ok;
		logic [3:0]  nib;
		at = word_len;
		nib_ok = 1'b1;
		if (is_numeral(c)) nib = 4'(c - "0");
		else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
		else begin
			nib_ok = 1'b0;
			nib = 4'd0;
		end
		if (at < 6) head[at] = c;
		// hex digits start after the "0x"
		if (at >= 2) begin
			if (nib_ok) hex_sum = {hex_sum[27:0], nib};
			else hex_ok = 1'b0;
		end
		if (is_numeral(c)) dec_sum = dec_sum * 32'd10 + 32'(c - "0");
		else if (at >= 1) dec_ok = 1'b0;
		if (at >= 1 && !is_letter(c) && !is_numeral(c) && c != CH_US) name_ok = 1'b0;
		// arg number: optional sign right after "arg", then the leading digits
		if (at >= 3 && !arg_done) begin
			if (at == 3 && (c == CH_PLUS || c == CH_MINUS)) begin
				if (c == CH_MINUS) arg_minus = 1'b1;
			end else if (is_numeral(c)) begin
				arg_sum = arg_sum * 32'd10 + 32'(c - "0");
			end else begin
				arg_done = 1'b1;
			end
		end
		if (word_len < MAX_LEN) word_len++;
	endtask

	// Kind and value of the word collected so far; last is left low
	function automatic token_result_t classify_word();
		token_result_t r;
		logic [7:0]    h1;
		string         kw;
		logic          hit;
		h1 = (word_len >= 2) ? head[1] : 8'd0;
		r.kind  = KIND_BROKEN;
		r.value = 32'd0;
		r.last  = 1'b0;
		if (word_len >= MAX_LEN) return r;
		if (head[0] == CH_ZERO && h1 == CH_X) begin
			if (hex_ok) begin
				r.kind  = KIND_LITERAL;
				r.value = hex_sum;
			end
			return r;
		end
		if (is_numeral(head[0]) || (head[0] == CH_MINUS && is_numeral(h1))) begin
			if (dec_ok) begin
				r.kind  = KIND_LITERAL;
				r.value = (head[0] == CH_MINUS) ? 32'd0 - dec_sum : dec_sum;
			end
			return r;
		end
		for (int i = 0; i < NUM_KW; i++) begin
			kw = keyword_spelling(i);
			hit = (kw.len() == word_len);
			for (int j = 0; j < kw.len(); j++) begin
				if (head[j] != kw[j]) hit = 1'b0;
			end
			if (hit) begin
				r.kind = KIND_KW0 + 5'(i);
				return r;
			end
		end
		if (word_len >= 3 && head[0] == CH_A && h1 == CH_R && head[2] == CH_G) begin
			r.kind  = KIND_ARG;
			r.value = arg_minus ? 32'd0 - arg_sum : arg_sum;
			return r;
		end
		if (is_letter(head[0]) && name_ok) r.kind = KIND_IDENT;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_result_t want;
		if (!arst_n) begin
			expected_tokens.delete();
			scan = SCAN_GAP;
			open_word();
			mismatch_count  = 0;
			results_checked = 0;
			kinds_seen      = '0;
			pending_count  <= 0;
		end else begin
			// input beat: advance the predictor
			if (in_valid && in_ready) begin
				if (end_of_input) begin
					// an open word is flushed first, then the end marker
					if (scan == SCAN_WORD) begin
						want = classify_word();
						expected_tokens.push_back(want);
					end
					want = '{kind: KIND_END, value: 32'd0, last: 1'b1};
					expected_tokens.push_back(want);
					scan = SCAN_GAP;
					open_word();
				end else begin
					case (scan)
						SCAN_REMARK: begin
							if (character == CH_NL) scan = SCAN_GAP;
						end
						SCAN_WORD: begin
							if (is_blank(character)) begin
								want = classify_word();
								want.last = 1'b1;
								expected_tokens.push_back(want);
								scan = SCAN_GAP;
							end else begin
								absorb_byte(character);
							end
						end
						default: begin
							if (character == CH_SEMI) begin
								scan = SCAN_REMARK;
							end else if (!is_blank(character)) begin
								open_word();
								absorb_byte(character);
								scan = SCAN_WORD;
							end
						end
					endcase
				end
			end

			// output beat: compare with the oldest prediction
			if (out_valid && out_ready) begin
				results_checked++;
				if (token_kind <= KIND_END) kinds_seen[token_kind] = 1'b1;
				if (expected_tokens.size() == 0) begin
					report_mismatch("token result with none expected", 32'(token_kind), 32'd0);
				end else begin
					want = expected_tokens.pop_front();
					if (token_kind !== want.kind)
						report_mismatch("token_kind", 32'(token_kind), 32'(want.kind));
					if (token_value !== want.value)
						report_mismatch("token_value", token_value, want.value);
					if (last_result !== want.last)
						report_mismatch("last_result", 32'(last_result), 32'(want.last));
				end
			end
			pending_count <= expected_tokens.size();
		end
	end

endmodule

@@ dv/keyword_literal_lexer_tb.sv @@
// Top of the lexer testbench: clock, reset, byte stream, result sink and verdict.
module keyword_literal_lexer_tb;
	import kll_pkg::*;

	localparam int unsigned ITEMS_TOTAL = 800;
	localparam int unsigned CALM_TAIL   = 120;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned MAX_LEN     = MAX_TOKEN_LEN_DEF;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic [7:0]         character    = 8'h00;
	logic               end_of_input = 1'b0;
	logic               out_ready    = 1'b1;
	logic               in_ready;
	logic               out_valid;
	logic [4:0]         token_kind;
	logic signed [31:0] token_value;
	logic               last_result;

	int unsigned pending_count;
	int unsigned mismatch_count;
	int unsigned results_checked;
	logic [26:0] kinds_seen;

	int unsigned beats_sent   = 0;
	int unsigned ends_sent    = 0;
	int unsigned gap_odds     = 0;
	int unsigned long_words   = 0;
	int unsigned quiet_cycles = 0;
	logic        calm         = 1'b0;
	logic [7:0]  token_bytes [$];

	keyword_literal_lexer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.character    (character),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_value  (token_value),
		.last_result  (last_result)
	);

	keyword_literal_lexer_checker #(
		.MAX_LEN (MAX_LEN)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.character       (character),
		.end_of_input    (end_of_input),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.token_kind      (token_kind),
		.token_value     (token_value),
		.last_result     (last_result),
		.pending_count   (pending_count),
		.mismatch_count  (mismatch_count),
		.results_checked (results_checked),
		.kinds_seen      (kinds_seen)
	);

	always #2 clk = ~clk;

	// Watchdog: cycles in which no beat moves on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("Timed out: no beat moved for %0d cycles", STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Result sink: random stall bursts until the calm tail
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	function automatic string keyword_text(input int idx);
		case (idx)
			0: return "defun";
			1: return "return";
			2: return "+";
			3: return "-";
			4: return "*";
			5: return "/";
			6: return "%";
			7: return "and";
			8: return "or";
			9: return "not";
			10: return "lt";
			11: return "le";
			12: return "eq";
			13: return "ge";
			14: return "gt";
			15: return "if";
			16: return "else";
			17: return "endif";
			18: return "drop";
			19: return "dup";
			20: return "swap";
			default: return "rot";
		endcase
	endfunction

	// Literals at the edges of the 32-bit range, wrap cases and odd shapes
	function automatic string extreme_text(input int idx);
		case (idx)
			0: return "0xFFFFFFFF";
			1: return "0x80000000";
			2: return "0x123456789";
			3: return "0x";
			4: return "2147483647";
			5: return "2147483648";
			6: return "-2147483648";
			7: return "4294967295";
			8: return "4294967296";
			9: return "-0";
			10: return "0";
			11: return "arg4294967297";
			12: return "arg-2147483648";
			default: return "-x";
		endcase
	endfunction

	function automatic logic [7:0] blank_byte();
		int unsigned r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : 8'(9 + r);
	endfunction

	// Any byte that does not end a word
	function automatic logic [7:0] solid_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13)) b = b ^ 8'h40;
		return b;
	endfunction

	function automatic logic [7:0] digit_byte();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] letter_byte();
		int unsigned r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] name_byte();
		int unsigned r;
		r = $urandom_range(0, 62);
		if (r < 52) return letter_byte();
		if (r < 62) return digit_byte();
		return CH_US;
	endfunction

	function automatic logic [7:0] hex_byte();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) token_bytes.push_back(s[i]);
	endtask

	// One beat on the input channel, with an optional idle burst in front
	task automatic send_beat(input logic [7:0] c, input logic eoi);
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		character    <= c;
		end_of_input <= eoi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
		if (eoi) ends_sent++;
		if (beats_sent % 64 == 0) gap_odds = 4 * $urandom_range(0, 3);
		if (beats_sent + CALM_TAIL >= ITEMS_TOTAL) calm = 1'b1;
	endtask

	task automatic send_queued();
		foreach (token_bytes[i]) send_beat(token_bytes[i], 1'b0);
	endtask

	task automatic send_text(input string s);
		token_bytes.delete();
		push_text(s);
		send_queued();
	endtask

	// Hold the stream until the lexer has delivered every predicted result
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// Build one word of the chosen flavour into token_bytes
	task automatic fill_token(input int unsigned pick);
		int unsigned n;
		logic        numeric;
		token_bytes.delete();
		case (pick)
			0, 1, 2, 3: begin
				push_text(keyword_text($urandom_range(0, NUM_KW - 1)));
			end
			4, 5: begin
				push_text("0x");
				n = $urandom_range(0, 10);
				repeat (n) token_bytes.push_back(hex_byte());
			end
			6, 7: begin
				if ($urandom_range(0, 2) == 0) token_bytes.push_back(CH_MINUS);
				n = $urandom_range(1, 12);
				repeat (n) token_bytes.push_back(digit_byte());
			end
			8, 9: begin
				push_text("arg");
				case ($urandom_range(0, 3))
					0: token_bytes.push_back(CH_PLUS);
					1: token_bytes.push_back(CH_MINUS);
					default: ;
				endcase
				n = $urandom_range(0, 11);
				repeat (n) token_bytes.push_back(digit_byte());
				// trailing junk after the number is ignored
				if ($urandom_range(0, 3) == 0) begin
					n = $urandom_range(1, 3);
					repeat (n) token_bytes.push_back(solid_byte());
				end
			end
			10, 11: begin
				token_bytes.push_back(letter_byte());
				n = $urandom_range(0, 10);
				repeat (n) token_bytes.push_back(name_byte());
			end
			12: begin
				// keyword with one byte too many or too few
				push_text(keyword_text($urandom_range(0, NUM_KW - 1)));
				if ($urandom_range(0, 1) == 1) token_bytes.push_back(name_byte());
				else void'(token_bytes.pop_back());
			end
			13: begin
				push_text(extreme_text($urandom_range(0, 13)));
			end
			14, 15: begin
				// well-formed word with one byte spoilt
				fill_token($urandom_range(0, 11));
				token_bytes[$urandom_range(0, token_bytes.size() - 1)] = solid_byte();
			end
			16, 17: begin
				n = $urandom_range(1, 8);
				repeat (n) token_bytes.push_back(solid_byte());
				if (token_bytes[0] == CH_SEMI) token_bytes[0] = "#";
			end
			18: begin
				// identifier shape with a non-letter start
				token_bytes.push_back(($urandom_range(0, 1) == 1) ? CH_US : digit_byte());
				n = $urandom_range(0, 6);
				repeat (n) token_bytes.push_back(name_byte());
			end
			default: begin
				// words just below, at and just above the length limit
				n = MAX_LEN - 2 + $urandom_range(0, 4);
				numeric = ($urandom_range(0, 1) == 1);
				token_bytes.push_back(numeric ? digit_byte() : letter_byte());
				repeat (n - 1) token_bytes.push_back(numeric ? digit_byte() : name_byte());
			end
		endcase
	endtask

	initial begin
		int unsigned pick;
		logic [7:0]  b;
		logic        drained;
		drained = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bare "0x", negative literal, bad identifier start with ';' inside,
		// comment closed by end of stream, arg with sign cut by end, lone end, operator
		send_text("0x\t-9 _a;b\n;c");
		send_beat(8'hA5, 1'b1);
		send_text("arg-12");
		send_beat(8'h5A, 1'b1);
		send_beat(8'hFF, 1'b1);
		send_text("% ");
		wait_for_results();

		// Random words separated by whitespace, comments and end marks
		while (beats_sent < ITEMS_TOTAL) begin
			pick = $urandom_range(0, 19);
			if (pick == 19 && (long_words >= 2 || $urandom_range(0, 3) != 0)) pick = 10;
			if (pick == 19) long_words++;
			fill_token(pick);
			send_queued();

			pick = $urandom_range(0, 39);
			if (pick == 0) begin
				// end mark with the word still open
				send_beat(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				send_beat(blank_byte(), 1'b0);
				if (pick <= 5) begin
					token_bytes.delete();
					token_bytes.push_back(CH_SEMI);
					repeat ($urandom_range(0, 10)) begin
						b = 8'($urandom_range(0, 255));
						if (b == CH_NL) b = 8'h0B;
						token_bytes.push_back(b);
					end
					if (pick == 5) begin
						send_queued();
						send_beat(8'($urandom_range(0, 255)), 1'b1);
					end else begin
						token_bytes.push_back(CH_NL);
						send_queued();
					end
				end else if (pick == 6) begin
					send_beat(8'($urandom_range(0, 255)), 1'b1);
				end else if (pick <= 14) begin
					send_beat(blank_byte(), 1'b0);
				end
			end

			if (!drained && beats_sent >= ITEMS_TOTAL / 2) begin
				drained = 1'b1;
				wait_for_results();
			end
		end
		send_beat(8'($urandom_range(0, 255)), 1'b1);

		// Drain, let the pipeline settle, then the verdict
		wait_for_results();
		repeat (8) @(posedge clk);
		$display("Run covered %0d input beats with %0d end marks, %0d token results checked",
			beats_sent, ends_sent, results_checked);
		$display("%0d of %0d token kinds seen at the output, %0d words near the length limit",
			$countones(kinds_seen), KIND_END + 1, long_words);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
